// File: sv/ddm_pkg.sv
// Shared types and constants for the decimal digit multiplier.
`timescale 1ns / 1ps

package ddm_pkg;

  // Largest legal decimal digit code
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [3:0] RADIX     = 4'd10;
  // Reciprocal of ten for column values below one hundred: q = (v * 205) >> 11
  localparam logic [7:0] RECIP_TEN   = 8'd205;
  localparam int         RECIP_SHIFT = 11;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_LAT,
    ST_STEP_RD,
    ST_STEP_MAC,
    ST_STEP_WR,
    ST_CARRY_WR,
    ST_OUT_RD,
    ST_OUT_SHOW
  } ddm_state_e;

  // Operands for one digit step of the shared multiply-accumulate unit
  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] p;
    logic [3:0] c;
  } ddm_mac_in_t;

  // Result of one digit step
  typedef struct packed {
    logic [3:0] digit;
    logic [3:0] carry;
  } ddm_mac_out_t;

  // Operand capture status
  typedef struct packed {
    logic complete;
    logic error;
  } ddm_load_status_t;

endpackage

// File: sv/ddm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ddm_ram #(
  parameter int WIDTH  = 4,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/ddm_mac.sv
// Shared digit multiply-accumulate unit with decimal split.
`timescale 1ns / 1ps

module ddm_mac (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  ddm_pkg::ddm_mac_in_t mac_i,
  output ddm_pkg::ddm_mac_out_t mac_o
);

  import ddm_pkg::*;

  logic [7:0]  prod;
  logic [6:0]  v_d;
  logic [6:0]  v_q;
  logic [14:0] recip;
  logic [3:0]  quot;
  logic [7:0]  tens;

  // v = p + a*b + c, at most 99
  assign prod = mac_i.a * mac_i.b;
  assign v_d  = prod[6:0] + {3'b000, mac_i.p} + {3'b000, mac_i.c};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
    end
  end

  // Split the registered column value into digit and carry
  assign recip = v_q * RECIP_TEN;
  assign quot  = recip[RECIP_SHIFT+3:RECIP_SHIFT];
  assign tens  = quot * RADIX;

  assign mac_o.carry = quot;
  assign mac_o.digit = v_q[3:0] - tens[3:0];

endmodule

// File: sv/ddm_loader.sv
// Operand capture: digit counts, completion flags and sticky error.
`timescale 1ns / 1ps

module ddm_loader #(
  parameter int MAX_DIGITS = 16,
  parameter int CW = $clog2(MAX_DIGITS + 1),
  parameter int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic                       func_i,
  input  logic [3:0]                 digit_i,
  input  logic                       operand_end_i,
  input  logic                       clear_i,
  output logic                       wr_first_o,
  output logic                       wr_second_o,
  output logic [AW-1:0]              wr_addr_o,
  output logic [3:0]                 wr_data_o,
  output logic [CW-1:0]              first_count_o,
  output logic [CW-1:0]              second_count_o,
  output ddm_pkg::ddm_load_status_t  status_o
);

  import ddm_pkg::*;

  logic [CW-1:0] f_cnt_q, f_cnt_d, s_cnt_q, s_cnt_d;
  logic          f_done_q, f_done_d, s_done_q, s_done_d;
  logic          err_q, err_d;
  logic          sel_done;
  logic          take;
  logic          room;
  logic          bad_code;
  logic [CW-1:0] cnt;

  assign sel_done = func_i ? s_done_q : f_done_q;
  assign cnt      = func_i ? s_cnt_q : f_cnt_q;
  assign take     = fire_i && !sel_done;
  assign room     = cnt < CW'(MAX_DIGITS);
  assign bad_code = digit_i > DIGIT_MAX;

  // Store write for an accepted digit with room left
  assign wr_first_o  = take && !func_i && room;
  assign wr_second_o = take && func_i && room;
  assign wr_addr_o   = cnt[AW-1:0];
  assign wr_data_o   = bad_code ? 4'd0 : digit_i;

  always_comb begin
    f_cnt_d  = f_cnt_q;
    s_cnt_d  = s_cnt_q;
    f_done_d = f_done_q;
    s_done_d = s_done_q;
    err_d    = err_q;
    if (clear_i) begin
      f_cnt_d  = '0;
      s_cnt_d  = '0;
      f_done_d = 1'b0;
      s_done_d = 1'b0;
      err_d    = 1'b0;
    end else if (take) begin
      if (bad_code || !room) begin
        err_d = 1'b1;
      end
      if (room) begin
        if (func_i) begin
          s_cnt_d = s_cnt_q + 1'b1;
        end else begin
          f_cnt_d = f_cnt_q + 1'b1;
        end
      end
      if (operand_end_i) begin
        if (func_i) begin
          s_done_d = 1'b1;
        end else begin
          f_done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_cnt_q  <= '0;
      s_cnt_q  <= '0;
      f_done_q <= 1'b0;
      s_done_q <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      f_cnt_q  <= f_cnt_d;
      s_cnt_q  <= s_cnt_d;
      f_done_q <= f_done_d;
      s_done_q <= s_done_d;
      err_q    <= err_d;
    end
  end

  assign first_count_o     = f_cnt_q;
  assign second_count_o    = s_cnt_q;
  assign status_o.complete = f_done_q && s_done_q;
  assign status_o.error    = err_q;

endmodule

// File: sv/decimal_digit_multiplier_core.sv
// Top level: schoolbook decimal multiplier with digit stores and step sequencer.
`timescale 1ns / 1ps
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, func_i, digit_i,   | input
//          | operand_end_i                             |
//  out     | out_valid_o/out_ready_i, product_digit_o, | output
//          | last_o, bad_input_o                       |
//
//  Each digit transfer takes one cycle while the block is loading.
//  Once both operands are complete the shared multiply-accumulate unit takes each
//  digit pair through read, multiply-accumulate and write states; each multiplier
//  row adds row read, latch and carry write. Output reads, then shows, la+lb digits.
//  Input is not ready from completion until the last product digit transfers;
//  an output stall simply holds the shown digit. No clearing pass after reset.

module decimal_digit_multiplier_core #(
  parameter int MAX_DIGITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [3:0] digit_i,
  input  logic       operand_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] product_digit_o,
  output logic       last_o,
  output logic       bad_input_o
);

  import ddm_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PW = $clog2(2 * MAX_DIGITS);
  localparam int TW = $clog2(2 * MAX_DIGITS + 1);

  ddm_state_e       state_q, state_d;
  logic [CW-1:0]    i_q, i_d, j_q, j_d;
  logic [PW-1:0]    k_q, k_d;
  logic [3:0]       b_q, b_d;
  logic [3:0]       carry_q, carry_d;

  logic             in_fire;
  logic             clear;
  logic             wr_first, wr_second;
  logic [AW-1:0]    ld_addr;
  logic [3:0]       ld_data;
  logic [CW-1:0]    la, lb;
  logic [TW-1:0]    total;
  ddm_load_status_t status;

  logic             a_rd_en, b_rd_en, p_rd_en, p_wr_en, mac_en;
  logic [CW-1:0]    a_idx, b_idx;
  logic [AW-1:0]    a_rd_addr, b_rd_addr;
  logic [PW-1:0]    p_rd_addr, p_wr_addr;
  logic [3:0]       p_wr_data;
  logic [3:0]       a_rdata, b_rdata, p_rdata;
  logic [TW-1:0]    out_idx;
  logic             last_row, last_col, last_out;
  ddm_mac_in_t      mac_in;
  ddm_mac_out_t     mac_out;

  assign in_ready_o = (state_q == ST_IDLE) && !status.complete;
  assign in_fire    = in_valid_i && in_ready_o;
  assign total      = TW'(la) + TW'(lb);

  ddm_loader #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_loader (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (in_fire),
    .func_i         (func_i),
    .digit_i        (digit_i),
    .operand_end_i  (operand_end_i),
    .clear_i        (clear),
    .wr_first_o     (wr_first),
    .wr_second_o    (wr_second),
    .wr_addr_o      (ld_addr),
    .wr_data_o      (ld_data),
    .first_count_o  (la),
    .second_count_o (lb),
    .status_o       (status)
  );

  // Digit stores, least significant digit at the highest filled address
  ddm_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS), .ADDR_W(AW)) u_first_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_first),
    .wr_addr_i (ld_addr),
    .wr_data_i (ld_data),
    .rd_en_i   (a_rd_en),
    .rd_addr_i (a_rd_addr),
    .rd_data_o (a_rdata)
  );

  ddm_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS), .ADDR_W(AW)) u_second_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_second),
    .wr_addr_i (ld_addr),
    .wr_data_i (ld_data),
    .rd_en_i   (b_rd_en),
    .rd_addr_i (b_rd_addr),
    .rd_data_o (b_rdata)
  );

  // Product store, index 0 is the least significant digit
  ddm_ram #(.WIDTH(4), .DEPTH(2 * MAX_DIGITS), .ADDR_W(PW)) u_prod_ram (
    .clk_i     (clk_i),
    .wr_en_i   (p_wr_en),
    .wr_addr_i (p_wr_addr),
    .wr_data_i (p_wr_data),
    .rd_en_i   (p_rd_en),
    .rd_addr_i (p_rd_addr),
    .rd_data_o (p_rdata)
  );

  // Column i+j reads as zero on the first row, so no clearing is needed
  assign mac_in.a = a_rdata;
  assign mac_in.b = b_q;
  assign mac_in.p = (j_q == '0) ? 4'd0 : p_rdata;
  assign mac_in.c = carry_q;

  ddm_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .mac_i (mac_in),
    .mac_o (mac_out)
  );

  // Addresses
  assign a_idx     = la - 1'b1 - i_q;
  assign b_idx     = lb - 1'b1 - j_q;
  assign a_rd_addr = a_idx[AW-1:0];
  assign b_rd_addr = b_idx[AW-1:0];
  assign out_idx   = total - 1'b1 - TW'(k_q);
  assign last_col  = (i_q == la - 1'b1);
  assign last_row  = (j_q == lb - 1'b1);
  assign last_out  = (TW'(k_q) == total - 1'b1);

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    b_d       = b_q;
    carry_d   = carry_q;
    a_rd_en   = 1'b0;
    b_rd_en   = 1'b0;
    p_rd_en   = 1'b0;
    p_wr_en   = 1'b0;
    mac_en    = 1'b0;
    clear     = 1'b0;
    p_rd_addr = PW'(i_q) + PW'(j_q);
    p_wr_addr = PW'(i_q) + PW'(j_q);
    p_wr_data = mac_out.digit;
    case (state_q)
      ST_IDLE: begin
        if (status.complete) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        b_rd_en = 1'b1;
        state_d = ST_ROW_LAT;
      end
      ST_ROW_LAT: begin
        b_d     = b_rdata;
        carry_d = 4'd0;
        state_d = ST_STEP_RD;
      end
      ST_STEP_RD: begin
        a_rd_en = 1'b1;
        p_rd_en = 1'b1;
        state_d = ST_STEP_MAC;
      end
      ST_STEP_MAC: begin
        mac_en  = 1'b1;
        state_d = ST_STEP_WR;
      end
      ST_STEP_WR: begin
        p_wr_en = 1'b1;
        carry_d = mac_out.carry;
        if (last_col) begin
          state_d = ST_CARRY_WR;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_STEP_RD;
        end
      end
      ST_CARRY_WR: begin
        // Row carry lands in a column no earlier row has reached
        p_wr_en   = 1'b1;
        p_wr_addr = PW'(la) + PW'(j_q);
        p_wr_data = carry_q;
        i_d       = '0;
        if (last_row) begin
          k_d     = '0;
          state_d = ST_OUT_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_ROW_RD;
        end
      end
      ST_OUT_RD: begin
        p_rd_en   = 1'b1;
        p_rd_addr = out_idx[PW-1:0];
        state_d   = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        if (out_ready_i) begin
          if (last_out) begin
            clear   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    b_q     <= b_d;
    carry_q <= carry_d;
  end

  // Result channel
  assign out_valid_o     = (state_q == ST_OUT_SHOW);
  assign product_digit_o = p_rdata;
  assign last_o          = last_out;
  assign bad_input_o     = status.error;

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a product digit is shown");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (product_digit_o <= DIGIT_MAX))
    else $error("product digit above nine");

  a_carry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP_WR) |-> (mac_out.carry <= DIGIT_MAX))
    else $error("column carry above nine");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("not ready for new operands after the last product digit");

endmodule
